>>> sv/lst_pkg.sv
// ----------------------------------------------------------------------------
// Line splitter package
// Types, register indexes and character codes shared by the line splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_FORWARD_LONG   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIM_LEADING   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRIM_TRAILING  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DROP_COMMENT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DROP_BLANK     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_APPEND_NUL     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_APPEND_NEWLINE = 3'd6;

  localparam logic [7:0] CHR_HASH = 8'h23;
  localparam logic [7:0] CHR_NL   = 8'h0A;
  localparam logic [7:0] CHR_NUL  = 8'h00;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } lst_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_last;
    logic       line_truncated;
  } lst_out_t;

  typedef struct packed {
    logic forward_long_lines;
    logic trim_leading;
    logic trim_trailing;
    logic drop_comment_lines;
    logic drop_blank_lines;
    logic append_nul;
    logic append_newline;
  } lst_cfg_t;

  typedef enum logic [1:0] {
    RD_START,
    RD_TAIL,
    RD_INDEX
  } lst_rd_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIN_CHK,
    ST_LEAD_RD,
    ST_LEAD_CHK,
    ST_TRAIL_RD,
    ST_TRAIL_CHK,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_TERM_NL,
    ST_TERM_NUL
  } lst_state_e;

  typedef struct packed {
    logic        in_ready;
    logic        store;
    logic        clear;
    logic        latch;
    logic        lead_step;
    logic        trail_step;
    logic        emit_byte;
    logic        emit_nl;
    logic        emit_nul;
    lst_rd_sel_e rd_sel;
  } lst_cmd_t;

  typedef struct packed {
    logic     in_valid;
    logic     in_kind;
    logic     in_is_nl;
    logic     line_empty;
    logic     drop_trunc;
    logic     len_zero;
    logic     len_gt1;
    logic     idx_last;
    logic     rd_space;
    logic     rd_hash;
    logic     slot_free;
    lst_cfg_t fcfg;
  } lst_status_t;

  function automatic logic is_c_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

>>> sv/text_line_splitter_trim.sv
// ----------------------------------------------------------------------------
// Text line splitter with whitespace trim
// Splits a byte stream into lines, then trims, filters and optionally terminates each line.
// ----------------------------------------------------------------------------
// A data byte is written to the line store as it is taken, while there is
// room. A newline, or end of stream with a pending line, starts the finishing
// pass, during which no input is taken. A truncated line that is dropped ends
// at the first check. Otherwise the pass reads and checks one byte at a time
// to trim whitespace at either end, when that trim is enabled and the line is
// long enough to trim. The blank and comment checks follow, the comment check
// reading the first byte, and a dropped line ends there. A line that is kept
// reads and emits each content byte in turn, then passes through both of the
// terminator slots, whether that terminator is enabled or not, and waits out
// any output stall. These steps follow from the single read port of the line
// store, whose read data is registered.
`default_nettype none

module text_line_splitter_trim import lst_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lst_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lst_out_t                out_data_o
);

  lst_cmd_t    cmd;
  lst_status_t status;

  lst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .cmd_o   (cmd)
  );

  lst_dp #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

  assign in_ready_o = cmd.in_ready;

endmodule

`default_nettype wire

>>> sv/lst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/lst_ctrl.sv
// ----------------------------------------------------------------------------
// Line splitter controller
// Sequences storing, trimming, filtering and emission of each line.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_ctrl import lst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lst_status_t status_i,
  output lst_cmd_t         cmd_o
);

  lst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          if (!status_i.in_kind && !status_i.in_is_nl) begin
            state_d = ST_IDLE;
          end else if (status_i.in_kind && status_i.line_empty) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FIN_CHK;
          end
        end
      end
      ST_FIN_CHK: begin
        state_d = status_i.drop_trunc ? ST_IDLE : ST_LEAD_RD;
      end
      ST_LEAD_RD: begin
        if (status_i.fcfg.trim_leading && !status_i.len_zero) begin
          state_d = ST_LEAD_CHK;
        end else begin
          state_d = ST_TRAIL_RD;
        end
      end
      ST_LEAD_CHK: begin
        state_d = status_i.rd_space ? ST_LEAD_RD : ST_TRAIL_RD;
      end
      ST_TRAIL_RD: begin
        if (status_i.fcfg.trim_trailing && status_i.len_gt1) begin
          state_d = ST_TRAIL_CHK;
        end else begin
          state_d = ST_HEAD_RD;
        end
      end
      ST_TRAIL_CHK: begin
        state_d = status_i.rd_space ? ST_TRAIL_RD : ST_HEAD_RD;
      end
      ST_HEAD_RD: begin
        if (status_i.len_zero) begin
          state_d = status_i.fcfg.drop_blank_lines ? ST_IDLE : ST_TERM_NL;
        end else begin
          state_d = ST_HEAD_CHK;
        end
      end
      ST_HEAD_CHK: begin
        if (status_i.fcfg.drop_comment_lines && status_i.rd_hash) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (status_i.slot_free) begin
          state_d = status_i.idx_last ? ST_TERM_NL : ST_EMIT_RD;
        end
      end
      ST_TERM_NL: begin
        if (!status_i.fcfg.append_newline || status_i.slot_free) begin
          state_d = ST_TERM_NUL;
        end
      end
      ST_TERM_NUL: begin
        if (!status_i.fcfg.append_nul || status_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.in_ready   = 1'b0;
    cmd_o.store      = 1'b0;
    cmd_o.clear      = 1'b0;
    cmd_o.latch      = 1'b0;
    cmd_o.lead_step  = 1'b0;
    cmd_o.trail_step = 1'b0;
    cmd_o.emit_byte  = 1'b0;
    cmd_o.emit_nl    = 1'b0;
    cmd_o.emit_nul   = 1'b0;
    cmd_o.rd_sel     = RD_START;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          if (!status_i.in_kind && !status_i.in_is_nl) begin
            cmd_o.store = 1'b1;
          end else if (status_i.in_kind && status_i.line_empty) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
          end
        end
      end
      ST_LEAD_CHK: begin
        cmd_o.lead_step = status_i.rd_space;
      end
      ST_TRAIL_RD: begin
        cmd_o.rd_sel = RD_TAIL;
      end
      ST_TRAIL_CHK: begin
        cmd_o.rd_sel     = RD_TAIL;
        cmd_o.trail_step = status_i.rd_space;
      end
      ST_EMIT_RD: begin
        cmd_o.rd_sel = RD_INDEX;
      end
      ST_EMIT_WAIT: begin
        cmd_o.rd_sel    = RD_INDEX;
        cmd_o.emit_byte = status_i.slot_free;
      end
      ST_TERM_NL: begin
        cmd_o.emit_nl = status_i.fcfg.append_newline && status_i.slot_free;
      end
      ST_TERM_NUL: begin
        cmd_o.emit_nul = status_i.fcfg.append_nul && status_i.slot_free;
      end
      default: begin
        cmd_o.rd_sel = RD_START;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/lst_dp.sv
// ----------------------------------------------------------------------------
// Line splitter datapath
// Configuration, line store, trim pointers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_dp import lst_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire lst_in_t            in_data_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output lst_out_t                out_data_o,
  input  wire lst_cmd_t           cmd_i,
  output lst_status_t             status_o
);

  localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [LW-1:0] Depth = LW'(BUFFER_BYTES);
  localparam logic [LW-1:0] One   = LW'(1);

  lst_cfg_t      cfg_q, fcfg_q;
  logic [LW-1:0] len_q, flen_q, start_q, idx_q;
  logic          ovf_q, trunc_q;
  logic          out_valid_q;
  lst_out_t      out_q;

  logic [LW-1:0] cap;
  logic          room;
  logic          we;
  logic [LW-1:0] rd_full;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          slot_free;

  assign cap  = Depth - LW'(cfg_q.append_nul) - LW'(cfg_q.append_newline);
  assign room = (len_q < cap) && (len_q < Depth);
  assign we   = cmd_i.store && room;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_START: rd_full = start_q;
      RD_TAIL:  rd_full = start_q + flen_q - One;
      RD_INDEX: rd_full = start_q + idx_q;
      default:  rd_full = start_q;
    endcase
  end

  assign raddr = rd_full[AW-1:0];

  lst_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(len_q[AW-1:0]),
    .wdata_i(in_data_i.in_byte),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{forward_long_lines: 1'b0, trim_leading: 1'b1, trim_trailing: 1'b1,
                 drop_comment_lines: 1'b1, drop_blank_lines: 1'b1, append_nul: 1'b1,
                 append_newline: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORWARD_LONG:   cfg_q.forward_long_lines <= cfg_wdata_i;
        CFG_TRIM_LEADING:   cfg_q.trim_leading       <= cfg_wdata_i;
        CFG_TRIM_TRAILING:  cfg_q.trim_trailing      <= cfg_wdata_i;
        CFG_DROP_COMMENT:   cfg_q.drop_comment_lines <= cfg_wdata_i;
        CFG_DROP_BLANK:     cfg_q.drop_blank_lines   <= cfg_wdata_i;
        CFG_APPEND_NUL:     cfg_q.append_nul         <= cfg_wdata_i;
        CFG_APPEND_NEWLINE: cfg_q.append_newline     <= cfg_wdata_i;
        default:            cfg_q                    <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear || cmd_i.latch) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.store) begin
      if (room) begin
        len_q <= len_q + One;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // The line's length, truncation flag and config are latched at its end, so the fill state is free again at once.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      fcfg_q  <= cfg_q;
      flen_q  <= (len_q > cap) ? cap : len_q;
      trunc_q <= ovf_q || (len_q > cap);
      start_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.lead_step) begin
        start_q <= start_q + One;
      end
      if (cmd_i.lead_step || cmd_i.trail_step) begin
        flen_q <= flen_q - One;
      end
      if (cmd_i.emit_byte) begin
        idx_q <= idx_q + One;
      end
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_byte || cmd_i.emit_nl || cmd_i.emit_nul) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_byte) begin
      out_q.out_byte       <= rdata;
      out_q.line_last      <= status_o.idx_last && !fcfg_q.append_newline &&
                              !fcfg_q.append_nul;
      out_q.line_truncated <= trunc_q;
    end else if (cmd_i.emit_nl) begin
      out_q.out_byte       <= CHR_NL;
      out_q.line_last      <= !fcfg_q.append_nul;
      out_q.line_truncated <= trunc_q;
    end else if (cmd_i.emit_nul) begin
      out_q.out_byte       <= CHR_NUL;
      out_q.line_last      <= 1'b1;
      out_q.line_truncated <= trunc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o.in_valid   = in_valid_i;
    status_o.in_kind    = in_data_i.kind;
    status_o.in_is_nl   = (in_data_i.in_byte == CHR_NL);
    status_o.line_empty = (len_q == '0);
    status_o.drop_trunc = trunc_q && !fcfg_q.forward_long_lines;
    status_o.len_zero   = (flen_q == '0);
    status_o.len_gt1    = (flen_q > One);
    status_o.idx_last   = (idx_q == flen_q - One);
    status_o.rd_space   = is_c_space(rdata);
    status_o.rd_hash    = (rdata == CHR_HASH);
    status_o.slot_free  = slot_free;
    status_o.fcfg       = fcfg_q;
  end

endmodule

`default_nettype wire

>>> sv/lst_chk.sv
// ----------------------------------------------------------------------------
// Line splitter port checker
// Checks the port behaviour of the line splitter over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_chk import lst_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire lst_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire lst_out_t out_data_o
);

  // A stalled result holds its value until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // A newline transfer starts the finishing pass, so input is closed next cycle.
  a_nl_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.kind && (in_data_i.in_byte == CHR_NL)
    |=> !in_ready_o)
    else $error("input still open after a newline");

  // Ordinary data bytes are stored at once while there is room, and input stays open.
  a_data_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.kind && (in_data_i.in_byte != CHR_NL)
    |=> in_ready_o)
    else $error("input closed after a data byte");

endmodule

bind text_line_splitter_trim lst_chk u_lst_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
